// ===== rtl/bhdc_pkg.sv =====
// shared types and codes for the button hold duration classifier
package bhdc_pkg;

    typedef enum logic [1:0] {
        CFG_ENABLED     = 2'd0,
        CFG_DEBOUNCE_MS = 2'd1,
        CFG_REBOOT_MS   = 2'd2,
        CFG_FACTORY_MS  = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_SHORT   = 2'd1,
        ACT_REBOOT  = 2'd2,
        ACT_FACTORY = 2'd3
    } t_action;

    typedef enum logic {
        OP_START  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_operation;

    localparam int CFG_DATA_W  = 20;
    localparam int DEBOUNCE_W  = 16;
    localparam int HOLD_W      = 20;
    localparam int STAMP_W     = 32;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [HOLD_W-1:0]     REBOOT_RESET   = 20'd3000;
    localparam logic [HOLD_W-1:0]     FACTORY_RESET  = 20'd10000;

endpackage

// ===== rtl/button_hold_duration_classifier_core.sv =====
// button hold duration classifier: debounce, press timing and action report
// a request is held in the input register, then classified into the result register
// throughput: one request per cycle while the receiver does not stall, set by the single
// compare stage between the input register and the result register
// reset: synchronous active low, clears handshake state, press state and
// timestamps, and loads the register defaults (disabled, 50, 3000, 10000 ms)
module button_hold_duration_classifier_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  bhdc_pkg::t_cfg_index                i_cfg_index,
    input  logic [bhdc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_operation,
    input  logic [bhdc_pkg::STAMP_W-1:0]        i_now_ms,
    input  logic                                i_level,
    output logic                                o_valid,
    input  logic                                i_stall,
    output bhdc_pkg::t_action                   o_action,
    output logic [bhdc_pkg::STAMP_W-1:0]        o_held_ms
);
    import bhdc_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > HOLD_W) ? TIME_WIDTH : HOLD_W;

    logic                    r_enabled;
    logic [DEBOUNCE_W-1:0]   r_debounce_ms;
    logic [HOLD_W-1:0]       r_reboot_ms;
    logic [HOLD_W-1:0]       r_factory_ms;

    logic                    r_s1_valid;
    logic                    r_s1_op;
    logic [TIME_WIDTH-1:0]   r_s1_now;
    logic                    r_s1_lvl;

    logic                    r_raw_level;
    logic                    r_stable_level;
    logic                    r_press_active;
    logic                    r_action_done;
    logic [TIME_WIDTH-1:0]   r_press_start;
    logic [TIME_WIDTH-1:0]   r_last_change;

    logic                    r_out_valid;
    t_action                 r_action;
    logic [STAMP_W-1:0]      r_held_ms;

    logic                    n_raw_level;
    logic                    n_stable_level;
    logic                    n_press_active;
    logic                    n_action_done;
    logic [TIME_WIDTH-1:0]   n_press_start;
    logic [TIME_WIDTH-1:0]   n_last_change;
    t_action                 n_action;
    logic [TIME_WIDTH-1:0]   n_held;

    logic                    advance;
    logic                    s1_fire;
    logic                    in_fire;
    logic [TIME_WIDTH-1:0]   since_change;
    logic [TIME_WIDTH-1:0]   since_press;
    logic                    debounced;
    logic                    over_factory;
    logic                    over_reboot;

    assign advance = !r_out_valid || !i_stall;
    assign s1_fire = r_s1_valid && advance;
    assign o_stall = r_s1_valid && !advance;
    assign in_fire = i_valid && !o_stall;

    assign since_change = r_s1_now - r_last_change;
    assign since_press  = r_s1_now - r_press_start;
    assign debounced    = CMP_W'(since_change) >= CMP_W'(r_debounce_ms);
    assign over_factory = CMP_W'(since_press) >= CMP_W'(r_factory_ms);
    assign over_reboot  = CMP_W'(since_press) >= CMP_W'(r_reboot_ms);

    always_comb begin
        n_raw_level    = r_raw_level;
        n_stable_level = r_stable_level;
        n_press_active = r_press_active;
        n_action_done  = r_action_done;
        n_press_start  = r_press_start;
        n_last_change  = r_last_change;
        n_action       = ACT_NONE;
        n_held         = '0;
        if (r_s1_op == OP_START) begin
            n_raw_level    = r_s1_lvl;
            n_stable_level = r_s1_lvl;
            n_last_change  = r_s1_now;
            if (!r_s1_lvl) begin
                n_press_active = 1'b1;
                n_press_start  = r_s1_now;
            end
        end else if (r_enabled) begin
            if (r_s1_lvl != r_raw_level) begin
                n_raw_level   = r_s1_lvl;
                n_last_change = r_s1_now;
            end else if (debounced) begin
                if (r_s1_lvl == r_stable_level) begin
                    // factory reset reported once while still held
                    if (r_press_active && !r_action_done && over_factory) begin
                        n_action_done = 1'b1;
                        n_action      = ACT_FACTORY;
                    end
                end else begin
                    if (!r_s1_lvl) begin
                        n_press_active = 1'b1;
                        n_action_done  = 1'b0;
                        n_press_start  = r_s1_now;
                    end else if (r_press_active) begin
                        n_press_active = 1'b0;
                        n_held         = since_press;
                        if (r_action_done) begin
                            n_action = ACT_NONE;
                        end else if (over_factory) begin
                            n_action = ACT_FACTORY;
                        end else if (over_reboot) begin
                            n_action = ACT_REBOOT;
                        end else begin
                            n_action = ACT_SHORT;
                        end
                    end
                    n_stable_level = r_s1_lvl;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled     <= 1'b0;
            r_debounce_ms <= DEBOUNCE_RESET;
            r_reboot_ms   <= REBOOT_RESET;
            r_factory_ms  <= FACTORY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENABLED:     r_enabled     <= i_cfg_data[0];
                CFG_DEBOUNCE_MS: r_debounce_ms <= i_cfg_data[DEBOUNCE_W-1:0];
                CFG_REBOOT_MS:   r_reboot_ms   <= i_cfg_data;
                CFG_FACTORY_MS:  r_factory_ms  <= i_cfg_data;
                default:         r_enabled     <= r_enabled;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op  <= i_operation;
            r_s1_now <= TIME_WIDTH'(i_now_ms);
            r_s1_lvl <= i_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_level    <= 1'b1;
            r_stable_level <= 1'b1;
            r_press_active <= 1'b0;
            r_action_done  <= 1'b0;
            r_press_start  <= '0;
            r_last_change  <= '0;
        end else if (s1_fire) begin
            r_raw_level    <= n_raw_level;
            r_stable_level <= n_stable_level;
            r_press_active <= n_press_active;
            r_action_done  <= n_action_done;
            r_press_start  <= n_press_start;
            r_last_change  <= n_last_change;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_action  <= n_action;
            r_held_ms <= STAMP_W'(n_held);
        end
    end

    assign o_valid   = r_out_valid;
    assign o_action  = r_action;
    assign o_held_ms = r_held_ms;

`ifndef SYNTH
    a_release_needs_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_press_active) |-> $past(s1_fire))
        else $error("press ended without a request in flight");

    a_stall_means_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid && r_out_valid)
        else $error("input stalled with room downstream");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |-> !s1_fire)
        else $error("result overwritten while stalled");

    a_held_after_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_held_ms != '0 |-> !r_press_active)
        else $error("hold time reported while press still active");
`endif

endmodule

// ===== tb/sv/tb_button_hold_duration_classifier_core.sv =====
// testbench for the button hold duration classifier: random press sequences checked by a scoreboard
`timescale 1ns / 1ps

module tb_button_hold_duration_classifier_core;
    import bhdc_pkg::*;

    localparam int ITEM_GOAL      = 1650;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 200;

    class press_action_scoreboard;
        typedef struct packed {
            t_action     action;
            logic [31:0] held;
        } t_action_report;

        t_action_report expected_actions[$];
        int errors;

        logic        en;
        logic [15:0] debounce;
        logic [19:0] reboot;
        logic [19:0] factory;

        logic        raw_lvl;
        logic        stable_lvl;
        logic        pressed;
        logic        reported;
        logic [31:0] press_t0;
        logic [31:0] change_t;

        function new();
            errors     = 0;
            en         = 1'b0;
            debounce   = DEBOUNCE_RESET;
            reboot     = REBOOT_RESET;
            factory    = FACTORY_RESET;
            raw_lvl    = 1'b1;
            stable_lvl = 1'b1;
            pressed    = 1'b0;
            reported   = 1'b0;
            press_t0   = '0;
            change_t   = '0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_ENABLED:     en = d[0];
                CFG_DEBOUNCE_MS: debounce = d[DEBOUNCE_W-1:0];
                CFG_REBOOT_MS:   reboot = d[HOLD_W-1:0];
                CFG_FACTORY_MS:  factory = d[HOLD_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(t_operation op, logic [31:0] now, logic lvl);
            t_action_report r;
            logic [31:0] since_change;
            logic [31:0] since_press;
            r.action     = ACT_NONE;
            r.held       = '0;
            since_change = now - change_t;
            since_press  = now - press_t0;
            if (op == OP_START) begin
                raw_lvl    = lvl;
                stable_lvl = lvl;
                change_t   = now;
                if (!lvl) begin
                    pressed  = 1'b1;
                    press_t0 = now;
                end
            end else if (en) begin
                if (lvl != raw_lvl) begin
                    raw_lvl  = lvl;
                    change_t = now;
                end else if (since_change >= debounce) begin
                    if (lvl == stable_lvl) begin
                        if (pressed && !reported && since_press >= factory) begin
                            reported = 1'b1;
                            r.action = ACT_FACTORY;
                        end
                    end else begin
                        if (!lvl) begin
                            pressed  = 1'b1;
                            reported = 1'b0;
                            press_t0 = now;
                        end else if (pressed) begin
                            pressed = 1'b0;
                            r.held  = since_press;
                            if (reported)
                                r.action = ACT_NONE;
                            else if (since_press >= factory)
                                r.action = ACT_FACTORY;
                            else if (since_press >= reboot)
                                r.action = ACT_REBOOT;
                            else
                                r.action = ACT_SHORT;
                        end
                        stable_lvl = lvl;
                    end
                end
            end
            expected_actions.push_back(r);
        endfunction

        function void flag_error(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void check_action(t_action act, logic [31:0] held);
            t_action_report want;
            if (expected_actions.size() == 0) begin
                flag_error($sformatf("unexpected result action %0d held %0d", act, held));
                return;
            end
            want = expected_actions.pop_front();
            if (act !== want.action)
                flag_error($sformatf("action expected %0d got %0d", want.action, act));
            if (held !== want.held)
                flag_error($sformatf("held_ms expected %0d got %0d", want.held, held));
        endfunction

        function int pending();
            return expected_actions.size();
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    t_cfg_index            i_cfg_index = CFG_ENABLED;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_valid     = 1'b0;
    logic                  i_operation = OP_SAMPLE;
    logic [STAMP_W-1:0]    i_now_ms    = '0;
    logic                  i_level     = 1'b1;
    logic                  i_stall     = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    t_action               o_action;
    logic [STAMP_W-1:0]    o_held_ms;

    logic req_fire;
    logic rsp_fire;

    press_action_scoreboard sb;

    int          counted       = 0;
    int          burst_left    = 0;
    bit          steady        = 1'b0;
    bit          long_hold_req = 1'b0;
    logic        cfg_en_now    = 1'b0;
    int          cfg_deb       = DEBOUNCE_RESET;
    int          cfg_reb       = REBOOT_RESET;
    int          cfg_fac       = FACTORY_RESET;
    logic [31:0] now_t         = '0;

    button_hold_duration_classifier_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_now_ms    (i_now_ms),
        .i_level     (i_level),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_action    (o_action),
        .o_held_ms   (o_held_ms)
    );

    always #10 i_clk = ~i_clk;

    assign req_fire = i_rst_n && i_valid && !o_stall;
    assign rsp_fire = i_rst_n && o_valid && !i_stall;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (req_fire)
                sb.note_request(t_operation'(i_operation), i_now_ms, i_level);
            if (rsp_fire)
                sb.check_action(o_action, o_held_ms);
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin : rx_stall_gen
        int mode;
        int len;
        int k;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(1, 40);
            for (k = 0; k < len; k++) begin
                if (long_hold_req)
                    break;
                case (mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_stall <= ($urandom_range(0, 1) == 0);
                    default: i_stall <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || req_fire || rsp_fire || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic pace();
        int gap;
        if (steady)
            return;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 9))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(13, 30);
                default: gap = $urandom_range(1, 12);
            endcase
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic offer(t_operation op, logic [31:0] now, logic lvl);
        pace();
        i_valid     <= 1'b1;
        i_operation <= op;
        i_now_ms    <= now;
        i_level     <= lvl;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        counted++;
    endtask

    task automatic drain();
        i_valid    <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_config(logic en, logic [15:0] deb, logic [19:0] reb, logic [19:0] fac);
        t_cfg_index order[4] = '{CFG_ENABLED, CFG_DEBOUNCE_MS, CFG_REBOOT_MS, CFG_FACTORY_MS};
        logic [CFG_DATA_W-1:0] d;
        foreach (order[k]) begin
            case (order[k])
                CFG_ENABLED:     d = {19'($urandom), en};
                CFG_DEBOUNCE_MS: d = {4'($urandom), deb};
                CFG_REBOOT_MS:   d = reb;
                default:         d = fac;
            endcase
            i_cfg_we    <= 1'b1;
            i_cfg_index <= order[k];
            i_cfg_data  <= d;
            @(posedge i_clk);
        end
        i_cfg_we   <= 1'b0;
        cfg_en_now = en;
        cfg_deb    = deb;
        cfg_reb    = reb;
        cfg_fac    = fac;
    endtask

    // debounced press, optional bounces and held samples, then a debounced release
    task automatic press_sequence();
        longint      target;
        longint      tc;
        longint      off;
        int unsigned top;
        int unsigned slack;
        logic [31:0] t;
        top = (cfg_reb > cfg_fac) ? cfg_reb : cfg_fac;
        case ($urandom_range(0, 5))
            0:       target = cfg_reb;
            1:       target = cfg_reb - 1;
            2:       target = cfg_fac;
            3:       target = cfg_fac - 1;
            default: target = $urandom_range(0, top + top / 4 + 100);
        endcase
        if (target < 0)
            target = 0;
        now_t += $urandom_range(1, 2 * cfg_deb + 300);
        offer(OP_SAMPLE, now_t, 1'b0);
        repeat ($urandom_range(0, 2)) begin
            now_t += $urandom_range(0, cfg_deb);
            offer(OP_SAMPLE, now_t, 1'b1);
            now_t += $urandom_range(0, cfg_deb);
            offer(OP_SAMPLE, now_t, 1'b0);
        end
        t = now_t + cfg_deb + $urandom_range(0, 2);
        offer(OP_SAMPLE, t, 1'b0);
        slack = $urandom_range(0, 2);
        tc    = target - cfg_deb - slack;
        if (tc < 0)
            tc = 0;
        off = 0;
        if (cfg_fac <= tc && $urandom_range(0, 1)) begin
            off = cfg_fac;
            offer(OP_SAMPLE, t + 32'(off), 1'b0);
        end
        repeat ($urandom_range(0, 3)) begin
            off += $urandom_range(0, 32'(tc - off));
            offer(OP_SAMPLE, t + 32'(off), 1'b0);
        end
        offer(OP_SAMPLE, t + 32'(tc), 1'b1);
        now_t = t + 32'(tc + cfg_deb + slack);
        offer(OP_SAMPLE, now_t, 1'b1);
    endtask

    task automatic noise_item();
        case ($urandom_range(0, 7))
            0:       now_t = $urandom;
            1:       ;
            default: now_t += $urandom_range(0, 2000);
        endcase
        offer(($urandom_range(0, 5) == 0) ? OP_START : OP_SAMPLE, now_t, 1'($urandom_range(0, 1)));
    endtask

    initial begin : main
        int phase;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // disabled after reset, sample before any start
        offer(OP_SAMPLE, 32'd100, 1'b0);
        drain();
        write_config(1'b1, DEBOUNCE_RESET, REBOOT_RESET, FACTORY_RESET);

        // short press with the debounce boundary hit exactly
        offer(OP_SAMPLE, 32'd1000, 1'b0);
        offer(OP_SAMPLE, 32'd1049, 1'b0);
        offer(OP_SAMPLE, 32'd1050, 1'b0);
        offer(OP_SAMPLE, 32'd3000, 1'b1);
        offer(OP_SAMPLE, 32'd3050, 1'b1);
        // start while pressed, factory while held, then release
        offer(OP_START, 32'd5000, 1'b0);
        offer(OP_SAMPLE, 32'd14999, 1'b0);
        offer(OP_SAMPLE, 32'd15000, 1'b0);
        offer(OP_SAMPLE, 32'd16000, 1'b0);
        offer(OP_SAMPLE, 32'd16010, 1'b1);
        offer(OP_SAMPLE, 32'd16060, 1'b1);
        // reboot at the exact threshold
        offer(OP_SAMPLE, 32'd20000, 1'b0);
        offer(OP_SAMPLE, 32'd20050, 1'b0);
        offer(OP_SAMPLE, 32'd22950, 1'b1);
        offer(OP_SAMPLE, 32'd23050, 1'b1);
        // start released while a press is still timed
        offer(OP_START, 32'd24000, 1'b0);
        offer(OP_START, 32'd24010, 1'b1);
        offer(OP_SAMPLE, 32'd40000, 1'b1);
        // timestamp wrap
        offer(OP_START, 32'hFFFF_FF00, 1'b0);
        offer(OP_SAMPLE, 32'h0000_0010, 1'b1);
        offer(OP_SAMPLE, 32'h0000_0042, 1'b1);
        offer(OP_SAMPLE, 32'hFFFF_FFFF, 1'b0);

        now_t = $urandom;
        phase = 0;
        while (counted < ITEM_GOAL) begin
            drain();
            case (phase % 7)
                0: write_config(1'b1, 16'd0, 20'd0, 20'd0);
                1: write_config(1'b1, 16'hFFFF, 20'hFFFFF, 20'hFFFFF);
                2: write_config(1'b0, 16'($urandom), 20'($urandom), 20'($urandom));
                3: write_config(1'b1, 16'($urandom_range(0, 100)), 20'($urandom_range(0, 4000)),
                                20'($urandom_range(0, 12000)));
                4: write_config(1'b1, 16'($urandom), 20'($urandom), 20'($urandom));
                5: begin
                    cfg_reb = $urandom_range(2000, 8000);
                    write_config(1'b1, 16'($urandom_range(0, 60)), 20'(cfg_reb),
                                 20'($urandom_range(0, cfg_reb - 1)));
                end
                default: write_config(1'b1, DEBOUNCE_RESET, REBOOT_RESET, FACTORY_RESET);
            endcase
            if ($urandom_range(0, 1))
                offer(OP_START, now_t, 1'($urandom_range(0, 1)));
            if (phase == 3) begin
                long_hold_req = 1'b1;
                steady        = 1'b1;
                repeat (12) press_sequence();
                steady = 1'b0;
            end
            repeat (cfg_en_now ? 45 : 12) begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 6)) noise_item();
                else
                    press_sequence();
            end
            phase++;
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (sb.pending() != 0)
            $display("%0d expected results never arrived", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== button_hold_duration_classifier_core.f =====
rtl/bhdc_pkg.sv
rtl/button_hold_duration_classifier_core.sv
tb/sv/tb_button_hold_duration_classifier_core.sv
